@@ hdl/plbp_pkg.sv @@
// shared constants, types and state codes of the piecewise linear branch predictor
// used by the predictor's cell and top modules and by its port checker
`default_nettype none

package plbp_pkg;

  localparam int DEF_TABLE_COUNT = 16;
  localparam int DEF_HISTORY_LEN = 15;
  localparam int DEF_WEIGHT_BITS = 8;

  localparam int ADDR_W       = 4;
  localparam int ADDR_SLOTS   = 16;
  localparam int THRESH_W     = 11;
  localparam int THRESH_RESET = 54;

  localparam int SUM_FIELD_W   = 12;
  localparam int SUM_FIELD_MAX = 2047;
  localparam int SUM_FIELD_MIN = -2048;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ACCUM,
    ST_WRITE
  } plbp_state_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
    logic shift;
    logic taken;
  } plbp_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/plbp_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module plbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/plbp_cell.sv @@
// one history position: its weight bank, its history slot and one partial-sum stage
// depends on plbp_pkg and plbp_ram
`default_nettype none

module plbp_cell
  import plbp_pkg::*;
#(
  parameter int TABLE_COUNT = DEF_TABLE_COUNT,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
  parameter int SUM_W       = 13,
  parameter bit BIAS        = 1'b0
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire plbp_ctrl_t                              ctrl,
  input  wire logic [$clog2(TABLE_COUNT)-1:0]          tbl,
  input  wire logic [$clog2(TABLE_COUNT*ADDR_SLOTS)-1:0] clear_row,
  input  wire logic [ADDR_W-1:0]                       hist_addr_in,
  input  wire logic                                    hist_taken_in,
  output logic      [ADDR_W-1:0]                       hist_addr,
  output logic                                         hist_taken,
  input  wire logic signed [SUM_W-1:0]                 psum_in,
  output logic      signed [SUM_W-1:0]                 psum
);

  localparam int ROWS  = TABLE_COUNT * ADDR_SLOTS;
  localparam int ROW_W = $clog2(ROWS);
  localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

  logic        [ROW_W-1:0]       row;
  logic        [ROW_W-1:0]       waddr;
  logic signed [WEIGHT_BITS-1:0] weight;
  logic signed [WEIGHT_BITS-1:0] wdata;
  logic signed [SUM_W-1:0]       wext;
  logic signed [SUM_W-1:0]       term;
  logic                          up;

  // bias position always uses address slot zero and always adds
  if (BIAS) begin : g_bias
    assign hist_addr  = '0;
    assign hist_taken = 1'b1;
  end else begin : g_hist
    always_ff @(posedge clk) begin
      if (rst) begin
        hist_addr  <= '0;
        hist_taken <= 1'b0;
      end else if (ctrl.shift) begin
        hist_addr  <= hist_addr_in;
        hist_taken <= hist_taken_in;
      end
    end
  end

  assign row   = {tbl, hist_addr};
  assign waddr = ctrl.clr ? clear_row : row;

  plbp_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.clr | ctrl.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctrl.rd_en),
    .raddr (row),
    .rdata (weight)
  );

  assign wext = SUM_W'(weight);
  assign term = hist_taken ? wext : -wext;

  // partial sum moves one cell down the row each cycle
  always_ff @(posedge clk) begin
    psum <= psum_in + term;
  end

  // zero during the clear sweep, else a saturating step toward agreement with the resolved outcome
  assign up = (hist_taken == ctrl.taken);

  always_comb begin
    if (ctrl.clr) begin
      wdata = '0;
    end else if (up) begin
      wdata = (weight == W_MAX) ? weight : weight + WEIGHT_BITS'(1);
    end else begin
      wdata = (weight == W_MIN) ? weight : weight - WEIGHT_BITS'(1);
    end
  end

endmodule

`default_nettype wire

@@ hdl/piecewise_linear_branch_predictor_top.sv @@
// piecewise linear branch predictor: one item at a time, busy stays high until its result
// result strobe done is raised in the write state, after the read and accumulate states; the partial sum
// ripples one cell per cycle through the HISTORY_LEN+1 cells during the accumulate state
// reset clears both histories at once, then sweeps all TABLE_COUNT*16 rows zeroing the
// weight banks with busy high; the receiver cannot stall, each result shows for one cycle
// depends on plbp_pkg and plbp_cell
`default_nettype none

module piecewise_linear_branch_predictor_top
  import plbp_pkg::*;
#(
  parameter int TABLE_COUNT = DEF_TABLE_COUNT,
  parameter int HISTORY_LEN = DEF_HISTORY_LEN,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ADDR_W-1:0]             branch_addr,
  input  wire logic                          outcome,
  output logic                               done,
  output logic                               predict_taken,
  output logic signed [SUM_FIELD_W-1:0]      perceptron_sum,
  output logic                               did_train,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [THRESH_W-1:0]           cfg_data
);

  localparam int POSITIONS = HISTORY_LEN + 1;
  localparam int TBL_W     = $clog2(TABLE_COUNT);
  localparam int ROWS      = TABLE_COUNT * ADDR_SLOTS;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int CNT_W     = $clog2(POSITIONS);
  localparam int SUM_W     = WEIGHT_BITS + $clog2(POSITIONS) + 1;
  localparam int EXT_W     = (SUM_W > SUM_FIELD_W + 1) ? SUM_W : SUM_FIELD_W + 1;
  localparam logic signed [EXT_W-1:0] FIELD_MAX = EXT_W'(SUM_FIELD_MAX);
  localparam logic signed [EXT_W-1:0] FIELD_MIN = EXT_W'(SUM_FIELD_MIN);

  plbp_state_t state, state_next;
  plbp_ctrl_t  ctrl;

  logic [ROW_W-1:0]      clear_row;
  logic [CNT_W-1:0]      acc_cnt;
  logic [TBL_W-1:0]      item_tbl;
  logic [ADDR_W-1:0]     item_addr;
  logic                  item_taken;
  logic [THRESH_W-1:0]   train_threshold;

  logic        [ADDR_W-1:0] hist_addr  [POSITIONS];
  logic                     hist_taken [POSITIONS];
  logic        [ADDR_W-1:0] hin_addr   [POSITIONS];
  logic                     hin_taken  [POSITIONS];
  logic signed [SUM_W-1:0]  psum       [POSITIONS];
  logic signed [SUM_W-1:0]  psum_in    [POSITIONS];

  logic signed [EXT_W-1:0] sum_ext;
  logic signed [EXT_W-1:0] thr_ext;
  logic                    pred;
  logic                    train;

  // address modulo table count by repeated subtraction on a 4-bit value
  function automatic logic [TBL_W-1:0] table_of(input logic [ADDR_W-1:0] a);
    logic [ADDR_W:0] r;
    r = {1'b0, a};
    for (int k = 0; k < 8; k++) begin
      if (r >= TABLE_COUNT) begin
        r = r - (ADDR_W+1)'(TABLE_COUNT);
      end
    end
    return TBL_W'(r);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      train_threshold <= THRESH_W'(THRESH_RESET);
    end else if (cfg_valid && cfg_ready) begin
      train_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_row <= '0;
      acc_cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_row <= clear_row + ROW_W'(1);
      end
      if (state == ST_ACCUM) begin
        acc_cnt <= acc_cnt + CNT_W'(1);
      end else begin
        acc_cnt <= '0;
      end
    end
  end

  // input transaction latch
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      item_addr  <= branch_addr;
      item_taken <= outcome;
      item_tbl   <= table_of(branch_addr);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_row == ROW_W'(ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_READ;
        end
      end
      ST_READ:  state_next = ST_ACCUM;
      ST_ACCUM: begin
        if (acc_cnt == CNT_W'(POSITIONS - 1)) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl       = '0;
    ctrl.taken = item_taken;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_CLEAR: ctrl.clr = 1'b1;
      ST_IDLE:  busy = 1'b0;
      ST_READ:  ctrl.rd_en = 1'b1;
      ST_ACCUM: ;
      ST_WRITE: begin
        ctrl.wr_en = train;
        ctrl.shift = 1'b1;
        done       = 1'b1;
      end
      default:  ;
    endcase
  end

  for (genvar i = 0; i < POSITIONS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign psum_in[i]   = '0;
      assign hin_addr[i]  = item_addr;
      assign hin_taken[i] = item_taken;
    end else if (i == 1) begin : g_first
      assign psum_in[i]   = psum[i-1];
      assign hin_addr[i]  = item_addr;
      assign hin_taken[i] = item_taken;
    end else begin : g_rest
      assign psum_in[i]   = psum[i-1];
      assign hin_addr[i]  = hist_addr[i-1];
      assign hin_taken[i] = hist_taken[i-1];
    end

    plbp_cell #(
      .TABLE_COUNT (TABLE_COUNT),
      .WEIGHT_BITS (WEIGHT_BITS),
      .SUM_W       (SUM_W),
      .BIAS        (i == 0)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .tbl           (item_tbl),
      .clear_row     (clear_row),
      .hist_addr_in  (hin_addr[i]),
      .hist_taken_in (hin_taken[i]),
      .hist_addr     (hist_addr[i]),
      .hist_taken    (hist_taken[i]),
      .psum_in       (psum_in[i]),
      .psum          (psum[i])
    );
  end

  // decision on the full sum from the end of the row
  assign sum_ext = EXT_W'(psum[POSITIONS-1]);
  assign thr_ext = signed'(EXT_W'(train_threshold));
  assign pred    = ~sum_ext[EXT_W-1];
  assign train   = (pred != item_taken) || ((sum_ext < thr_ext) && (sum_ext > -thr_ext));

  assign predict_taken = pred;
  assign did_train     = train;

  always_comb begin
    if (sum_ext > FIELD_MAX) begin
      perceptron_sum = SUM_FIELD_W'(FIELD_MAX);
    end else if (sum_ext < FIELD_MIN) begin
      perceptron_sum = SUM_FIELD_W'(FIELD_MIN);
    end else begin
      perceptron_sum = SUM_FIELD_W'(sum_ext);
    end
  end

endmodule

`default_nettype wire

@@ hdl/plbp_checker.sv @@
// port-level checks of the predictor's command handshake and result strobe
// depends on plbp_pkg; bound to piecewise_linear_branch_predictor_top
`default_nettype none

module plbp_checker
  import plbp_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     done,
  input wire logic                     predict_taken,
  input wire logic [SUM_FIELD_W-1:0]   perceptron_sum,
  input wire logic                     did_train
);

  // a result belongs to a transaction in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // the result strobe is never raised twice in a row
  a_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // prediction and sum sign agree, and a zero sum is predicted taken or trains
  a_sign: assert property (@(posedge clk) disable iff (rst)
    done |-> (predict_taken == !perceptron_sum[SUM_FIELD_W-1]))
    else $error("prediction disagrees with sum sign");

  a_train_zero: assert property (@(posedge clk) disable iff (rst)
    (done && perceptron_sum == '0) |-> (did_train || predict_taken))
    else $error("zero sum not predicted taken");

endmodule

bind piecewise_linear_branch_predictor_top plbp_checker u_plbp_checker (.*);

`default_nettype wire

@@ dv/piecewise_linear_branch_predictor_top_test.sv @@
// self-checking bench for the piecewise linear branch predictor: directed and random branch
// traces, a clocked driver fed from a step queue, a monitor checked against a local predictor
// depends on plbp_pkg and piecewise_linear_branch_predictor_top
`timescale 1ns / 100ps

module piecewise_linear_branch_predictor_top_test
  import plbp_pkg::*;
;

  localparam int TABLE_CNT     = DEF_TABLE_COUNT;
  localparam int HIST_LEN      = DEF_HISTORY_LEN;
  localparam int WEIGHT_W      = DEF_WEIGHT_BITS;
  localparam int WGT_MAX       = (1 << (WEIGHT_W - 1)) - 1;
  localparam int WGT_MIN       = -(1 << (WEIGHT_W - 1));
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_STEPS    = 150;
  localparam int TAIL_CYCLES   = 40;
  localparam int STALL_LIMIT   = 2000;

  typedef enum int {
    STEP_BRANCH,
    STEP_THRESH,
    STEP_DRAIN
  } step_kind_t;

  typedef enum int {
    PAT_TAKEN,
    PAT_NOT_TAKEN,
    PAT_ALTERNATE,
    PAT_RANDOM
  } branch_pattern_t;

  typedef struct {
    step_kind_t          kind;
    logic [ADDR_W-1:0]   addr;
    logic                taken;
    logic [THRESH_W-1:0] thresh;
  } bench_step_t;

  typedef struct packed {
    logic                          pred_taken;
    logic signed [SUM_FIELD_W-1:0] sum;
    logic                          trained;
  } branch_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [ADDR_W-1:0]      branch_addr = '0;
  logic                   outcome = 1'b0;
  logic                   done;
  logic                   predict_taken;
  logic signed [SUM_FIELD_W-1:0] perceptron_sum;
  logic                   did_train;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [THRESH_W-1:0]    cfg_data = '0;

  // predictor state, mirrors the block
  logic signed [WEIGHT_W-1:0] weights [TABLE_CNT][ADDR_SLOTS][HIST_LEN+1];
  logic [ADDR_W-1:0]          hist_addr [HIST_LEN];
  logic                       hist_taken [HIST_LEN];
  logic [THRESH_W-1:0]        thresh_model;

  bench_step_t    pending_steps [$];
  branch_result_t expected_results [$];
  int             branches_queued;
  int             mismatch_cnt;
  int             gap_left;
  int             gap_pct;
  int             quiet_cycles;
  int             accepted_branches;
  int             stall_cycles;

  piecewise_linear_branch_predictor_top #(
    .TABLE_COUNT (TABLE_CNT),
    .HISTORY_LEN (HIST_LEN),
    .WEIGHT_BITS (WEIGHT_W)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .branch_addr    (branch_addr),
    .outcome        (outcome),
    .done           (done),
    .predict_taken  (predict_taken),
    .perceptron_sum (perceptron_sum),
    .did_train      (did_train),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic signed [WEIGHT_W-1:0] nudged(input logic signed [WEIGHT_W-1:0] w,
                                                       input logic up);
    if (up) begin
      return (w == WGT_MAX) ? w : w + WEIGHT_W'(1);
    end
    return (w == WGT_MIN) ? w : w - WEIGHT_W'(1);
  endfunction

  function automatic void predict_branch(input logic [ADDR_W-1:0] addr, input logic taken);
    int             tbl;
    int             total;
    int             thr;
    int             shown;
    int             i;
    logic           pred;
    logic           trn;
    branch_result_t res;
    tbl = addr % TABLE_CNT;
    thr = int'(thresh_model);
    total = weights[tbl][0][0];
    for (i = 0; i < HIST_LEN; i++) begin
      if (hist_taken[i]) begin
        total = total + weights[tbl][hist_addr[i]][i+1];
      end else begin
        total = total - weights[tbl][hist_addr[i]][i+1];
      end
    end
    pred = (total >= 0);
    trn = (pred != taken) || (total < thr && total > -thr);
    if (trn) begin
      weights[tbl][0][0] = nudged(weights[tbl][0][0], taken);
      for (i = 0; i < HIST_LEN; i++) begin
        weights[tbl][hist_addr[i]][i+1] =
          nudged(weights[tbl][hist_addr[i]][i+1], hist_taken[i] == taken);
      end
    end
    for (i = HIST_LEN - 1; i >= 1; i--) begin
      hist_addr[i]  = hist_addr[i-1];
      hist_taken[i] = hist_taken[i-1];
    end
    hist_addr[0]  = addr;
    hist_taken[0] = taken;
    shown = total;
    if (shown > SUM_FIELD_MAX) shown = SUM_FIELD_MAX;
    if (shown < SUM_FIELD_MIN) shown = SUM_FIELD_MIN;
    res.pred_taken = pred;
    res.sum        = SUM_FIELD_W'(shown);
    res.trained    = trn;
    expected_results.push_back(res);
  endfunction

  task automatic push_branch(input logic [ADDR_W-1:0] addr, input logic taken);
    bench_step_t s;
    s.kind   = STEP_BRANCH;
    s.addr   = addr;
    s.taken  = taken;
    s.thresh = '0;
    pending_steps.push_back(s);
    branches_queued++;
  endtask

  task automatic push_thresh(input logic [THRESH_W-1:0] value);
    bench_step_t s;
    s.kind   = STEP_THRESH;
    s.addr   = '0;
    s.taken  = 1'b0;
    s.thresh = value;
    pending_steps.push_back(s);
  endtask

  task automatic push_drain();
    bench_step_t s;
    s.kind   = STEP_DRAIN;
    s.addr   = '0;
    s.taken  = 1'b0;
    s.thresh = '0;
    pending_steps.push_back(s);
  endtask

  // a loop: a few body branches with their own patterns, closed by a backward branch
  task automatic add_loop_trace(input int n_items);
    logic [ADDR_W-1:0] body_addr [4];
    branch_pattern_t   body_pat [4];
    logic [ADDR_W-1:0] back_addr;
    logic              t;
    int                body_len;
    int                trip;
    int                made;
    int                iter;
    int                j;
    body_len = $urandom_range(1, 4);
    for (j = 0; j < 4; j++) begin
      body_addr[j] = ADDR_W'($urandom);
      body_pat[j]  = branch_pattern_t'($urandom_range(0, 3));
    end
    back_addr = ADDR_W'($urandom);
    trip = $urandom_range(2, 10);
    made = 0;
    iter = 0;
    while (made < n_items) begin
      for (j = 0; j < body_len; j++) begin
        case (body_pat[j])
          PAT_TAKEN:     t = 1'b1;
          PAT_NOT_TAKEN: t = 1'b0;
          PAT_ALTERNATE: t = iter[0];
          default:       t = 1'($urandom_range(0, 1));
        endcase
        push_branch(body_addr[j], t);
        made++;
      end
      push_branch(back_addr, (iter % trip) != trip - 1);
      made++;
      iter++;
    end
  endtask

  task automatic add_run(input int n_items, input logic [ADDR_W-1:0] addr, input logic taken);
    int k;
    for (k = 0; k < n_items; k++) push_branch(addr, taken);
  endtask

  task automatic add_noise(input int n_items);
    int k;
    for (k = 0; k < n_items; k++) push_branch(ADDR_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic add_phase(input logic [THRESH_W-1:0] thresh, input int n_items);
    int goal;
    int pick;
    goal = branches_queued + n_items;
    push_thresh(thresh);
    while (branches_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        add_loop_trace($urandom_range(15, 40));
      end else if (pick < 85) begin
        add_run($urandom_range(10, 40), ADDR_W'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        add_noise($urandom_range(3, 12));
      end
      if ($urandom_range(0, 19) == 0) push_drain();
    end
  endtask

  // driver: one step at a time from the queue, updates the predictor on each transaction
  always @(posedge clk) begin : drive
    bench_step_t nxt;
    logic        nxt_start;
    logic        nxt_cfg;
    if (rst) begin
      start       <= 1'b0;
      cfg_valid   <= 1'b0;
      gap_left     = 0;
      quiet_cycles = 0;
    end else begin
      nxt_start = start;
      nxt_cfg   = cfg_valid;
      if (start && !busy) begin
        predict_branch(branch_addr, outcome);
        nxt_start = 1'b0;
        accepted_branches++;
        if (accepted_branches % 64 == 0) begin
          case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 20;
            default: gap_pct = 60;
          endcase
        end
        if (pending_steps.size() > TAIL_STEPS && $urandom_range(0, 99) < gap_pct) begin
          gap_left = $urandom_range(1, 12);
        end
      end
      if (cfg_valid && cfg_ready) begin
        thresh_model = cfg_data;
        nxt_cfg = 1'b0;
      end
      quiet_cycles = (expected_results.size() == 0 && !nxt_start) ? quiet_cycles + 1 : 0;
      if (!nxt_start && !nxt_cfg && pending_steps.size() != 0) begin
        nxt = pending_steps[0];
        case (nxt.kind)
          STEP_BRANCH: begin
            if (gap_left != 0) begin
              // the gap counts idle cycles of the block, so it shifts the next start
              if (!busy) gap_left--;
            end else begin
              nxt_start = 1'b1;
              branch_addr <= nxt.addr;
              outcome <= nxt.taken;
              void'(pending_steps.pop_front());
            end
          end
          STEP_THRESH: begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              nxt_cfg = 1'b1;
              cfg_data <= nxt.thresh;
              void'(pending_steps.pop_front());
            end
          end
          default: begin
            if (quiet_cycles >= 1) void'(pending_steps.pop_front());
          end
        endcase
      end
      start     <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  // monitor: every strobed result against the oldest prediction
  always @(posedge clk) begin : watch_results
    branch_result_t exp_res;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: predict_taken %0d sum %0d did_train %0d",
                 $time, predict_taken, perceptron_sum, did_train);
        mismatch_cnt++;
      end else begin
        exp_res = expected_results.pop_front();
        if (predict_taken !== exp_res.pred_taken) begin
          $display("%0t: predict_taken expected %0d actual %0d",
                   $time, exp_res.pred_taken, predict_taken);
          mismatch_cnt++;
        end
        if (perceptron_sum !== exp_res.sum) begin
          $display("%0t: perceptron_sum expected %0d actual %0d",
                   $time, exp_res.sum, perceptron_sum);
          mismatch_cnt++;
        end
        if (did_train !== exp_res.trained) begin
          $display("%0t: did_train expected %0d actual %0d",
                   $time, exp_res.trained, did_train);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int t;
    int s;
    int i;
    int k;
    for (t = 0; t < TABLE_CNT; t++)
      for (s = 0; s < ADDR_SLOTS; s++)
        for (i = 0; i <= HIST_LEN; i++) weights[t][s][i] = '0;
    for (i = 0; i < HIST_LEN; i++) begin
      hist_addr[i]  = '0;
      hist_taken[i] = 1'b0;
    end
    thresh_model      = THRESH_W'(THRESH_RESET);
    branches_queued   = 0;
    mismatch_cnt      = 0;
    gap_pct           = 20;
    accepted_branches = 0;
    stall_cycles      = 0;

    // directed: every address at the reset threshold, then a zero threshold
    for (k = 0; k < ADDR_SLOTS; k++) push_branch(ADDR_W'(k), k[0] ^ k[3]);
    push_thresh('0);
    push_branch(4'hf, 1'b1);
    push_branch(4'h0, 1'b0);
    push_branch(4'hf, 1'b0);
    push_branch(4'h0, 1'b1);
    push_branch(4'h7, 1'b1);
    push_branch(4'h8, 1'b0);

    // widest threshold trains every time: long runs drive weights into saturation
    push_thresh(11'h7ff);
    add_run(135, ADDR_W'($urandom), 1'b1);
    add_run(135, ADDR_W'($urandom), 1'b0);
    push_drain();
    add_phase(11'h7ff, 100);
    add_phase('0, 130);
    add_phase(THRESH_W'(THRESH_RESET), 130);
    add_phase(THRESH_W'($urandom_range(1, 127)), 130);
    push_drain();
    add_phase(THRESH_W'(1), 130);
    add_phase(THRESH_W'($urandom_range(0, 2047)), 130);
    add_phase(11'h7ff, 130);
    add_phase(THRESH_W'($urandom_range(128, 2047)), 130);
    add_phase(THRESH_W'(THRESH_RESET), 130);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending_steps.size() != 0 || start || cfg_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
